FILE: hw/rtl/cia_pkg.sv
`timescale 1ns / 1ps
package cia_pkg;
  localparam int DataWidth = 64;
  localparam int CntW = 7;

  localparam logic [4:0] K_MUL = 5'd0;
  localparam logic [4:0] K_EQ = 5'd1;
  localparam logic [4:0] K_NE = 5'd2;
  localparam logic [4:0] K_LT = 5'd3;
  localparam logic [4:0] K_LE = 5'd4;
  localparam logic [4:0] K_GT = 5'd5;
  localparam logic [4:0] K_GE = 5'd6;
  localparam logic [4:0] K_AND = 5'd7;
  localparam logic [4:0] K_OR = 5'd8;
  localparam logic [4:0] K_XOR = 5'd9;
  localparam logic [4:0] K_MOD = 5'd10;
  localparam logic [4:0] K_ADD = 5'd11;
  localparam logic [4:0] K_SUB = 5'd12;
  localparam logic [4:0] K_NEG = 5'd13;
  localparam logic [4:0] K_NOT = 5'd14;
  localparam logic [4:0] K_POW = 5'd15;
  localparam logic [4:0] K_IDIV = 5'd16;
  localparam logic [4:0] K_DIV = 5'd17;

  localparam logic [1:0] ST_INT = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_FLOAT = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MUL  = 6'b000100,
    S_POW  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;
endpackage

FILE: hw/rtl/checked_integer_alu_with_power.sv
`timescale 1ns / 1ps
// Checked 64-bit signed integer ALU.
// The input channel carries one operation per beat: tdata holds kind [4:0],
// operand_a [68:5], operand_b [132:69], a_undefined [133], b_undefined [134].
// The result channel carries one beat per input beat: tdata holds value
// [63:0] and status [65:64].
// Logic operations, compares, add, subtract and negate are registered into the
// result beat on acceptance. Multiply and divide each run a 64-step add/shift
// loop on shared registers and then a finish step. Power does one multiply on
// the shared shift-add multiplier for each one bit of the exponent and one
// square for each bit below the top one; the exponent sets its run time.
// One item is in flight at a time: in_tready is low from acceptance until the
// result beat is taken, and the next beat is accepted in the next cycle at the
// earliest. A stalled receiver holds the result beat stable.
// Reset clears the sequencer and drops out_tvalid; no result is pending.
module checked_integer_alu_with_power (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // kind, operand_a, operand_b, a_undefined, b_undefined
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // value, status
  output logic [71:0]  out_tdata
);
  import cia_pkg::*;

  state_t state_r, state_nxt;
  logic [4:0]  kind_r;
  logic [63:0] a_r, b_r, acc_r, x_r, y_r, base_r, e_r, res_r;
  logic [64:0] hi_r;
  logic        ovf_r, neg_r, phase_r;
  logic [CntW-1:0] cnt_r;
  logic [63:0] val_r;
  logic [1:0]  st_r;

  logic [4:0]  kind_i;
  logic [63:0] a_i, b_i;
  logic        ua_i, ub_i;
  assign kind_i = in_tdata[4:0];
  assign a_i = in_tdata[68:5];
  assign b_i = in_tdata[132:69];
  assign ua_i = in_tdata[133];
  assign ub_i = in_tdata[134];

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {6'd0, st_r, val_r};

  logic [63:0] ma, mb, sum, dif;
  logic [64:0] trial;
  logic        lt_ab, lt_ba;
  assign ma = a_i[63] ? -a_i : a_i;
  assign mb = b_i[63] ? -b_i : b_i;
  assign sum = a_i + b_i;
  assign dif = a_i - b_i;
  assign lt_ab = $signed(a_i) < $signed(b_i);
  assign lt_ba = $signed(b_i) < $signed(a_i);
  // Divide trial subtraction.
  assign trial = {hi_r[63:0], acc_r[63]} - {1'b0, y_r};

  logic [127:0] mprod;
  logic [64:0]  madd;
  assign madd = {1'b0, hi_r[63:0]} + {1'b0, (x_r[0] ? y_r : 64'd0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        if (ua_i || ub_i || kind_i > K_DIV) state_nxt = S_OUT;
        else if (kind_i == K_MUL) state_nxt = S_MUL;
        else if ((kind_i == K_MOD || kind_i == K_IDIV || kind_i == K_DIV) && b_i != 0)
          state_nxt = S_DIV;
        else if (kind_i == K_POW && !b_i[63] && b_i != 0) state_nxt = S_POW;
        else state_nxt = S_OUT;
      end
      S_DIV, S_MUL: if (cnt_r == CntW'(DataWidth - 1)) state_nxt = S_FIN;
      S_POW: if (e_r == 0 && !phase_r && cnt_r == 0) state_nxt = S_FIN;
      S_FIN: state_nxt = S_OUT;
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign mprod = {hi_r[63:0], x_r};

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        kind_r <= kind_i; a_r <= a_i; b_r <= b_i;
        cnt_r <= '0; hi_r <= '0; ovf_r <= 1'b0;
        neg_r <= a_i[63] ^ b_i[63];
        val_r <= '0; st_r <= ST_INT;
        acc_r <= ma; x_r <= ma; y_r <= mb;
        base_r <= a_i; e_r <= b_i; res_r <= 64'd1; phase_r <= 1'b0;
        if (kind_i == K_EQ || kind_i == K_NE) begin
          val_r <= {64{((kind_i == K_EQ) == ((ua_i && ub_i) ||
                    (!ua_i && !ub_i && a_i == b_i)))}};
        end else if (kind_i >= K_LT && kind_i <= K_GE) begin
          if (!ua_i && !ub_i)
            val_r <= {64{(kind_i == K_LT) ? lt_ab : (kind_i == K_LE) ? !lt_ba :
                      (kind_i == K_GT) ? lt_ba : !lt_ab}};
        end else if (kind_i == K_NOT) begin
          val_r <= ua_i ? '1 : ~a_i;
        end else if (kind_i == K_NEG) begin
          if (ua_i) st_r <= ST_UNDEF;
          else if (a_i == {1'b1, 63'd0}) st_r <= ST_FLOAT;
          else val_r <= -a_i;
        end else if (kind_i > K_DIV || ua_i || ub_i) begin
          st_r <= ST_UNDEF;
        end else begin
          unique case (kind_i)
            K_AND: val_r <= a_i & b_i;
            K_OR: val_r <= a_i | b_i;
            K_XOR: val_r <= a_i ^ b_i;
            K_ADD: if ((a_i[63] == b_i[63]) && (sum[63] != a_i[63])) st_r <= ST_FLOAT;
                   else val_r <= sum;
            K_SUB: if ((a_i[63] != b_i[63]) && (dif[63] != a_i[63])) st_r <= ST_FLOAT;
                   else val_r <= dif;
            K_POW: if (a_i == 0 && b_i == 0) st_r <= ST_UNDEF;
                   else if (b_i[63]) begin
                     if (a_i == 0) val_r <= '0;
                     else if (a_i == 64'd1) val_r <= 64'd1;
                     else st_r <= ST_FLOAT;
                   end else val_r <= 64'd1;
            K_MOD, K_IDIV, K_DIV: if (b_i == 0) st_r <= ST_DIVZ;
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (!trial[64]) hi_r <= {1'b0, trial[63:0]};
        else hi_r <= {1'b0, hi_r[62:0], acc_r[63]};
        acc_r <= {acc_r[62:0], ~trial[64]};
        cnt_r <= cnt_r + 1'b1;
      end
      S_MUL: begin
        hi_r <= {1'b0, madd[64:1]};
        x_r <= {madd[0], x_r[63:1]};
        cnt_r <= cnt_r + 1'b1;
      end
      S_POW: begin
        // Shift-add multiply of x_r by y_r, low 64 bits in x_r at the end.
        if (cnt_r != 0 || phase_r) begin
          hi_r <= {1'b0, madd[64:1]};
          x_r <= {madd[0], x_r[63:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(DataWidth - 1)) begin
            cnt_r <= '0;
            phase_r <= 1'b0;
            if (ovf_r) res_r <= {madd[0], x_r[63:1]};
            else base_r <= {madd[0], x_r[63:1]};
          end
        end else if (e_r != 0) begin
          // ovf_r selects the multiply: 1 for result*base, 0 for base*base.
          hi_r <= '0; phase_r <= 1'b1;
          if (e_r[0]) begin
            x_r <= res_r; y_r <= base_r; ovf_r <= 1'b1; e_r[0] <= 1'b0;
          end else begin
            x_r <= base_r; y_r <= base_r; ovf_r <= 1'b0; e_r <= e_r >> 1;
          end
        end
      end
      S_FIN: begin
        if (kind_r == K_POW) val_r <= res_r;
        else if (kind_r == K_MUL) begin
          if (hi_r[63:0] != 0 || mprod[63:0] > {1'b0, {63{1'b1}}} + {63'd0, neg_r})
            st_r <= ST_FLOAT;
          else val_r <= neg_r ? -mprod[63:0] : mprod[63:0];
        end else if (kind_r == K_MOD) begin
          val_r <= a_r[63] ? -hi_r[63:0] : hi_r[63:0];
        end else if (kind_r == K_DIV && hi_r[63:0] != 0) begin
          st_r <= ST_FLOAT;
        end else if (a_r == {1'b1, 63'd0} && b_r == '1) begin
          st_r <= ST_FLOAT;
        end else begin
          val_r <= neg_r ? -acc_r : acc_r;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cia_pkg::*;

  localparam int Limit = 20000000;
  localparam logic [63:0] Lmin = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Lmax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Ones = '1;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] a;
    logic [63:0] b;
    logic        ua;
    logic        ub;
  } op_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } res_t;

  typedef struct {
    op_t  op;
    logic known;
    res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;

  res_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  checked_integer_alu_with_power dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed_less(logic [63:0] x, logic [63:0] y);
    return $signed(x) < $signed(y);
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic res_t alu_result(op_t op);
    res_t r;
    logic [127:0] prod;
    logic [63:0] t, q, rem, base, e, acc;
    logic eq, neg;
    r.value = '0;
    r.status = ST_INT;
    if (op.kind == K_EQ || op.kind == K_NE) begin
      eq = (op.ua && op.ub) || (!op.ua && !op.ub && op.a == op.b);
      r.value = ((op.kind == K_EQ) == eq) ? Ones : '0;
    end else if (op.kind >= K_LT && op.kind <= K_GE) begin
      if (!op.ua && !op.ub) begin
        case (op.kind)
          K_LT: eq = signed_less(op.a, op.b);
          K_LE: eq = !signed_less(op.b, op.a);
          K_GT: eq = signed_less(op.b, op.a);
          default: eq = !signed_less(op.a, op.b);
        endcase
        r.value = eq ? Ones : '0;
      end
    end else if (op.kind == K_NOT) begin
      r.value = op.ua ? Ones : ~op.a;
    end else if (op.kind == K_NEG) begin
      if (op.ua) r.status = ST_UNDEF;
      else if (op.a == Lmin) r.status = ST_FLOAT;
      else r.value = -op.a;
    end else if (op.kind > K_DIV || op.ua || op.ub) begin
      r.status = ST_UNDEF;
    end else begin
      case (op.kind)
        K_MUL: begin
          prod = magnitude(op.a) * magnitude(op.b);
          neg = op.a[63] != op.b[63];
          if (prod > (neg ? {64'd0, Lmin} : {64'd0, Lmax})) r.status = ST_FLOAT;
          else r.value = neg ? -prod[63:0] : prod[63:0];
        end
        K_AND: r.value = op.a & op.b;
        K_OR: r.value = op.a | op.b;
        K_XOR: r.value = op.a ^ op.b;
        K_ADD: begin
          t = op.a + op.b;
          if (((op.a ^ t) & (op.b ^ t)) >> 63) r.status = ST_FLOAT;
          else r.value = t;
        end
        K_SUB: begin
          t = op.a - op.b;
          if (((op.a ^ op.b) & (op.a ^ t)) >> 63) r.status = ST_FLOAT;
          else r.value = t;
        end
        K_POW: begin
          if (op.a == 0 && op.b == 0) r.status = ST_UNDEF;
          else if (op.b[63]) begin
            if (op.a == 0) r.value = '0;
            else if (op.a == 1) r.value = 64'd1;
            else r.status = ST_FLOAT;
          end else begin
            acc = 64'd1;
            base = op.a;
            e = op.b;
            while (e != 0) begin
              if (e[0]) acc = acc * base;
              e = e >> 1;
              base = base * base;
            end
            r.value = acc;
          end
        end
        default: begin
          if (op.b == 0) r.status = ST_DIVZ;
          else begin
            q = magnitude(op.a) / magnitude(op.b);
            rem = magnitude(op.a) % magnitude(op.b);
            if (op.a[63]) rem = -rem;
            if (op.a[63] != op.b[63]) q = -q;
            if (op.kind == K_MOD) r.value = rem;
            else if (op.kind == K_DIV && rem != 0) r.status = ST_FLOAT;
            else if (op.a == Lmin && op.b == Ones) r.status = ST_FLOAT;
            else r.value = q;
          end
        end
      endcase
    end
    if (r.status != ST_INT) r.value = '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? Lmin + $urandom_range(0, 3)
                                     : Lmax - $urandom_range(0, 3);
      3: return 64'($signed($urandom));
      4: return {32'd0, $urandom} >> $urandom_range(0, 31);
      default: return 64'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic op_t rand_op();
    op_t op;
    op.kind = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                           : 5'($urandom_range(0, 17));
    op.a = rand64();
    op.b = rand64();
    if (op.kind == K_POW && $urandom_range(0, 3) != 0) op.b = $urandom_range(0, 70);
    if (op.kind == K_POW && $urandom_range(0, 9) == 0)
      op.b = {1'b0, 63'($urandom) | 63'h4000_0000_0000_0000};
    if ((op.kind == K_DIV || op.kind == K_IDIV) && $urandom_range(0, 2) == 0)
      op.a = op.b * 64'($signed($urandom_range(0, 200)) - 100);
    op.ua = $urandom_range(0, 11) == 0;
    op.ub = $urandom_range(0, 11) == 0;
    return op;
  endfunction

  task automatic send_beat(op_t op);
    int idle;
    idle = $urandom_range(0, 14);
    if (idle > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_tdata <= {1'b0, op.ub, op.ua, op.b, op.a, op.kind};
    in_tvalid <= 1'b1;
    pending_results.push_back(alu_result(op));
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic row_t mk(logic [4:0] k, logic [63:0] a, logic [63:0] b,
                              logic ua, logic ub, logic known, logic [63:0] v,
                              logic [1:0] s);
    row_t r;
    r.op = '{k, a, b, ua, ub};
    r.known = known;
    r.res = '{v, s};
    return r;
  endfunction

  row_t directed[$];

  initial begin
    res_t want;
    directed = '{
      mk(K_ADD, Lmax, 64'd1, 1'b0, 1'b0, 1'b1, 64'd0, ST_FLOAT),
      mk(K_SUB, Lmin, 64'd1, 1'b0, 1'b0, 1'b1, 64'd0, ST_FLOAT),
      mk(K_MUL, Lmin, Ones, 1'b0, 1'b0, 1'b1, 64'd0, ST_FLOAT),
      mk(K_MUL, Lmin, 64'd1, 1'b0, 1'b0, 1'b1, Lmin, ST_INT),
      mk(K_NEG, Lmin, 64'd0, 1'b0, 1'b0, 1'b1, 64'd0, ST_FLOAT),
      mk(K_NEG, 64'd0, 64'd0, 1'b1, 1'b0, 1'b1, 64'd0, ST_UNDEF),
      mk(K_NOT, 64'd0, 64'd0, 1'b1, 1'b0, 1'b1, Ones, ST_INT),
      mk(K_NOT, Lmax, Ones, 1'b0, 1'b1, 1'b1, Lmin, ST_INT),
      mk(K_EQ, 64'd5, 64'd7, 1'b1, 1'b1, 1'b1, Ones, ST_INT),
      mk(K_NE, 64'd5, 64'd5, 1'b1, 1'b0, 1'b1, Ones, ST_INT),
      mk(K_LT, 64'd0, 64'd9, 1'b1, 1'b0, 1'b1, 64'd0, ST_INT),
      mk(K_LE, Lmin, Lmax, 1'b0, 1'b0, 1'b1, Ones, ST_INT),
      mk(K_GT, Lmin, Lmax, 1'b0, 1'b0, 1'b1, 64'd0, ST_INT),
      mk(K_GE, Ones, Ones, 1'b0, 1'b0, 1'b1, Ones, ST_INT),
      mk(K_AND, Ones, Lmax, 1'b0, 1'b0, 1'b1, Lmax, ST_INT),
      mk(K_OR, Lmin, Lmax, 1'b0, 1'b1, 1'b1, 64'd0, ST_UNDEF),
      mk(K_XOR, Ones, Lmax, 1'b0, 1'b0, 1'b1, Lmin, ST_INT),
      mk(K_MOD, 64'd7, 64'd0, 1'b0, 1'b0, 1'b1, 64'd0, ST_DIVZ),
      mk(K_MOD, Lmin, Ones, 1'b0, 1'b0, 1'b1, 64'd0, ST_INT),
      mk(K_IDIV, Lmin, Ones, 1'b0, 1'b0, 1'b1, 64'd0, ST_FLOAT),
      mk(K_DIV, 64'd7, 64'd2, 1'b0, 1'b0, 1'b1, 64'd0, ST_FLOAT),
      mk(K_IDIV, -64'd7, 64'd2, 1'b0, 1'b0, 1'b0, 64'd0, ST_INT),
      mk(K_POW, 64'd0, 64'd0, 1'b0, 1'b0, 1'b1, 64'd0, ST_UNDEF),
      mk(K_POW, 64'd1, Lmin, 1'b0, 1'b0, 1'b1, 64'd1, ST_INT),
      mk(K_POW, 64'd3, Ones, 1'b0, 1'b0, 1'b1, 64'd0, ST_FLOAT),
      mk(K_POW, Ones, Lmax, 1'b0, 1'b0, 1'b0, 64'd0, ST_INT),
      mk(5'd31, 64'd1, 64'd1, 1'b0, 1'b0, 1'b1, 64'd0, ST_UNDEF)
    };
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) begin
      want = alu_result(directed[i].op);
      if (directed[i].known && want !== directed[i].res)
        report_mismatch("directed table row", 64'(i), 64'd0);
      send_beat(directed[i].op);
    end
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
    for (int i = 0; i < 400; i++) begin
      if (i == 150) hold_off = 1'b1;
      if (i == 160) hold_off = 1'b0;
      if (i == 300) begin
        in_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      send_beat(rand_op());
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int idle;
    @(negedge clk);
    forever begin
      idle = $urandom_range(0, 14);
      if (hold_off) idle = 600;
      if (idle > 0) begin
        out_tready <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[63:0], out_tdata[65:64]};
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected result beat %h at %0t", out_tdata, $realtime);
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) report_mismatch("value", got.value, want.value);
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
      end
    end
  end

  initial begin
    wait (stim_done && pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS checked_integer_alu_with_power");
    end else begin
      $display("FAIL checked_integer_alu_with_power");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("FAIL checked_integer_alu_with_power");
      $finish;
    end
  end
endmodule

FILE: files.f
hw/rtl/cia_pkg.sv
hw/rtl/checked_integer_alu_with_power.sv
tb/testbench.sv
